FILE: rtl/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// Types, codes and constants shared by the palette pixel expander files.
// ----------------------------------------------------------------------------
package ppe_pkg;

    // Default sizes for the top level parameters
    localparam int unsigned DEF_PALETTE_ENTRIES = 256;
    localparam int unsigned DEF_MAX_ROW_PIXELS  = 4096;

    // Field widths
    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned INDEX_W   = 8;
    localparam int unsigned PIXEL_W   = 24;
    localparam int unsigned IMG_W_W   = 13;
    localparam int unsigned PAD_W     = 4;
    localparam int unsigned BITS_W    = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 13;

    // Level scaling: restoring division of a 16-bit dividend, one bit a step
    localparam int unsigned DIV_STEPS = 2 * LEVEL_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int unsigned MAX_BITS  = LEVEL_W;

    localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 24'hFF_FFFF;

    // Input item kinds
    localparam logic KIND_PALETTE_WR = 1'b0;
    localparam logic KIND_PIXEL      = 1'b1;

    // Output modes
    typedef enum logic [1:0] {
        MODE_INDEX   = 2'd0,
        MODE_PALETTE = 2'd1,
        MODE_DIRECT  = 2'd2
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_IMAGE_WIDTH = 3'd1,
        CFG_PAD_PIXELS  = 3'd2,
        CFG_RED_BITS    = 3'd3,
        CFG_GREEN_BITS  = 3'd4,
        CFG_BLUE_BITS   = 3'd5,
        CFG_GRAYSCALE   = 3'd6
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_EMIT,
        ST_PAD
    } t_state;

    typedef struct packed {
        logic [1:0]           mode;
        logic [IMG_W_W-1:0]   image_width;
        logic [PAD_W-1:0]     pad_pixels;
        logic [BITS_W-1:0]    red_bits;
        logic [BITS_W-1:0]    green_bits;
        logic [BITS_W-1:0]    blue_bits;
        logic                 grayscale;
    } t_cfg;

    typedef struct packed {
        logic                 kind;
        logic [INDEX_W-1:0]   entry_index;
        logic [LEVEL_W-1:0]   red_level;
        logic [LEVEL_W-1:0]   green_level;
        logic [LEVEL_W-1:0]   blue_level;
    } t_pix_in;

    typedef struct packed {
        logic [PIXEL_W-1:0]   pixel_value;
        logic                 is_padding;
        logic                 row_last;
    } t_pix_out;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] value;
    } t_cfg_wr;

    // Reset values of the configuration registers
    localparam t_cfg CFG_RESET = '{
        mode:        2'(MODE_PALETTE),
        image_width: 13'd640,
        pad_pixels:  4'd0,
        red_bits:    4'd8,
        green_bits:  4'd8,
        blue_bits:   4'd8,
        grayscale:   1'b0
    };

endpackage

FILE: rtl/ppe_ifs.sv
// ----------------------------------------------------------------------------
// ppe_ifs
// Valid/ready channels of the palette pixel expander: source pixels and
// palette writes in, expanded pixels out, and configuration writes.
// ----------------------------------------------------------------------------
interface ppe_pix_if;
    import ppe_pkg::*;

    logic    valid;
    logic    ready;
    t_pix_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppe_out_if;
    import ppe_pkg::*;

    logic     valid;
    logic     ready;
    t_pix_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppe_cfg_if;
    import ppe_pkg::*;

    logic    valid;
    logic    ready;
    t_cfg_wr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ppe_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppe_cfg_regs
// Configuration register file. Takes one write transaction per cycle and
// ignores indexes beyond the register list.
// ----------------------------------------------------------------------------
module ppe_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ppe_cfg_if.sink        i_cfg,
    output ppe_pkg::t_cfg  o_cfg
);
    import ppe_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the register index and merge the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_MODE:        n_cfg.mode        = i_cfg.data.value[1:0];
                CFG_IMAGE_WIDTH: n_cfg.image_width = i_cfg.data.value[IMG_W_W-1:0];
                CFG_PAD_PIXELS:  n_cfg.pad_pixels  = i_cfg.data.value[PAD_W-1:0];
                CFG_RED_BITS:    n_cfg.red_bits    = i_cfg.data.value[BITS_W-1:0];
                CFG_GREEN_BITS:  n_cfg.green_bits  = i_cfg.data.value[BITS_W-1:0];
                CFG_BLUE_BITS:   n_cfg.blue_bits   = i_cfg.data.value[BITS_W-1:0];
                CFG_GRAYSCALE:   n_cfg.grayscale   = i_cfg.data.value[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/ppe_level_div.sv
// ----------------------------------------------------------------------------
// ppe_level_div
// Scales one color level to 8 bits as level*255/(2^bits-1), saturating at
// 255. Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppe_level_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ppe_pkg::LEVEL_W-1:0]   i_level,
    input  logic [ppe_pkg::BITS_W-1:0]    i_bits,
    output logic                          o_done,
    output logic [ppe_pkg::LEVEL_W-1:0]   o_level
);
    import ppe_pkg::*;

    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_CNT_W-1:0]   n_cnt;
    logic [LEVEL_W-1:0]     r_div;
    logic [LEVEL_W-1:0]     n_div;
    logic [LEVEL_W-1:0]     r_rem;
    logic [LEVEL_W-1:0]     n_rem;
    logic [2*LEVEL_W-1:0]   r_quo;
    logic [2*LEVEL_W-1:0]   n_quo;

    logic [BITS_W-1:0]      bits_clamped;
    logic [LEVEL_W:0]       rem_shift;
    logic                   fits;

    // Clamp the bit count to 1..8
    always_comb begin
        if (i_bits == '0) begin
            bits_clamped = BITS_W'(1);
        end else if (i_bits > BITS_W'(MAX_BITS)) begin
            bits_clamped = BITS_W'(MAX_BITS);
        end else begin
            bits_clamped = i_bits;
        end
    end

    assign rem_shift = {r_rem, r_quo[2*LEVEL_W-1]};
    assign fits      = (rem_shift >= {1'b0, r_div});

    // Load on start, otherwise run one division step while steps remain
    always_comb begin
        n_cnt = r_cnt;
        n_div = r_div;
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_start) begin
            n_cnt = DIV_CNT_W'(DIV_STEPS);
            n_div = LEVEL_W'(({1'b0, {LEVEL_W{1'b0}}} | (9'd1 << bits_clamped)) - 9'd1);
            n_rem = '0;
            n_quo = {i_level, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, i_level};
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - DIV_CNT_W'(1);
            n_rem = fits ? LEVEL_W'(rem_shift - {1'b0, r_div}) : rem_shift[LEVEL_W-1:0];
            n_quo = {r_quo[2*LEVEL_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done  = (r_cnt == '0);
    assign o_level = (|r_quo[2*LEVEL_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : r_quo[LEVEL_W-1:0];

endmodule

FILE: rtl/ppe_palette_mem.sv
// ----------------------------------------------------------------------------
// ppe_palette_mem
// Palette store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ppe_palette_mem #(
    parameter int unsigned ENTRIES = ppe_pkg::DEF_PALETTE_ENTRIES,
    parameter int unsigned ADDR_W  = $clog2(ENTRIES)
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic [ppe_pkg::PIXEL_W-1:0]   i_wr_data,
    input  logic                          i_rd_en,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    output logic [ppe_pkg::PIXEL_W-1:0]   o_rd_data
);
    import ppe_pkg::*;

    logic [PIXEL_W-1:0] r_mem [ENTRIES];
    logic [PIXEL_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/palette_pixel_expander.sv
// ----------------------------------------------------------------------------
// palette_pixel_expander
// Expands palette indexes or direct RGB pixels to 24-bit RGB pixels, row by row.
// ----------------------------------------------------------------------------
// Channels: i_pix carries source pixels and palette writes (kind selects),
// o_pix carries expanded pixels with padding and row-end flags, i_cfg writes
// the configuration registers and is always ready.
// One item is handled at a time. A source pixel is taken when the block is
// idle and its output pixel is valid on the next cycle; the block is idle
// again on the cycle after that pixel is taken, unless padding follows. In
// palette mode the lookup for an in-range index is issued in the accepting
// cycle and the registered read data feeds the output directly.
// A row end with padding sends its padding pixels from the pad state first.
// A palette write gives no output; the three levels are scaled in parallel
// by bit-serial dividers, 16 steps, then written.
// Reset clears the row position and restores the default configuration;
// palette contents are not cleared and must be written before use.
// When o_pix stalls, the pending pixel is held and i_pix is not ready.
// ----------------------------------------------------------------------------
module palette_pixel_expander #(
    parameter int unsigned PALETTE_ENTRIES = ppe_pkg::DEF_PALETTE_ENTRIES,
    parameter int unsigned MAX_ROW_PIXELS  = ppe_pkg::DEF_MAX_ROW_PIXELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppe_pix_if.sink     i_pix,
    ppe_out_if.source   o_pix,
    ppe_cfg_if.sink     i_cfg
);
    import ppe_pkg::*;

    localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam int unsigned COL_W  = $clog2(MAX_ROW_PIXELS);
    localparam int unsigned CMP_W  = ((IMG_W_W > COL_W) ? IMG_W_W : COL_W) + 1;

    t_cfg                 cfg;

    t_state               r_state;
    t_state               n_state;
    logic [COL_W-1:0]     r_col;
    logic [COL_W-1:0]     n_col;
    logic [PAD_W-1:0]     r_pad_cnt;
    logic [PAD_W-1:0]     n_pad_cnt;
    logic                 r_row_end;
    logic                 r_from_mem;
    logic [PIXEL_W-1:0]   r_value;
    logic [ADDR_W-1:0]    r_wr_addr;

    logic                 pix_acc;
    logic                 in_range;
    logic                 div_start;
    logic                 mem_wr;
    logic                 mem_rd;
    logic                 div_done;
    logic [2:0]           lane_done;
    logic [LEVEL_W-1:0]   lvl_r;
    logic [LEVEL_W-1:0]   lvl_g;
    logic [LEVEL_W-1:0]   lvl_b;
    logic [PIXEL_W-1:0]   rd_data;
    logic [PIXEL_W-1:0]   pix_value;
    logic [PIXEL_W-1:0]   fill_value;
    logic [CMP_W-1:0]     width_raw;
    logic [CMP_W-1:0]     width_eff;
    logic [CMP_W-1:0]     col_next;
    logic                 row_end;

    // Configuration registers
    ppe_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign in_range = ({1'b0, i_pix.data.entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));

    // Level scalers, one per color
    ppe_level_div u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_level (i_pix.data.red_level),
        .i_bits  (cfg.red_bits),
        .o_done  (lane_done[2]),
        .o_level (lvl_r)
    );

    ppe_level_div u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_level (cfg.grayscale ? i_pix.data.red_level : i_pix.data.green_level),
        .i_bits  (cfg.green_bits),
        .o_done  (lane_done[1]),
        .o_level (lvl_g)
    );

    ppe_level_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_level (cfg.grayscale ? i_pix.data.red_level : i_pix.data.blue_level),
        .i_bits  (cfg.blue_bits),
        .o_done  (lane_done[0]),
        .o_level (lvl_b)
    );

    assign div_done = &lane_done;

    // Palette store
    ppe_palette_mem #(
        .ENTRIES (PALETTE_ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_palette_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_wr_addr),
        .i_wr_data ({lvl_r, lvl_g, lvl_b}),
        .i_rd_en   (mem_rd),
        .i_rd_addr (i_pix.data.entry_index[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Clamp the row width to 1..MAX_ROW_PIXELS and find the row end
    always_comb begin
        width_raw = CMP_W'(cfg.image_width);
        if (width_raw == '0) begin
            width_eff = CMP_W'(1);
        end else if (width_raw > CMP_W'(MAX_ROW_PIXELS)) begin
            width_eff = CMP_W'(MAX_ROW_PIXELS);
        end else begin
            width_eff = width_raw;
        end
        col_next = CMP_W'(r_col) + CMP_W'(1);
        row_end  = (col_next >= width_eff);
    end

    assign pix_acc = i_pix.valid && (r_state == ST_IDLE);

    // Next state, row position and padding count
    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_pad_cnt = r_pad_cnt;
        div_start = 1'b0;
        mem_wr    = 1'b0;
        mem_rd    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_pix.valid) begin
                    if (i_pix.data.kind == KIND_PIXEL) begin
                        n_state   = ST_EMIT;
                        mem_rd    = (cfg.mode == MODE_PALETTE) && in_range;
                        n_col     = row_end ? '0 : col_next[COL_W-1:0];
                        n_pad_cnt = cfg.pad_pixels;
                    end else if (in_range) begin
                        n_state   = ST_SCALE;
                        div_start = 1'b1;
                    end
                end
            end
            ST_SCALE: begin
                if (div_done) begin
                    mem_wr  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (o_pix.ready) begin
                    n_state = (r_row_end && (r_pad_cnt != '0)) ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (o_pix.ready) begin
                    n_pad_cnt = r_pad_cnt - PAD_W'(1);
                    if (r_pad_cnt == PAD_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_col     <= '0;
            r_pad_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_pad_cnt <= n_pad_cnt;
        end
    end

    // Capture the pixel payload on accept
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_row_end  <= row_end;
            r_from_mem <= (cfg.mode == MODE_PALETTE) && in_range;
            r_wr_addr  <= i_pix.data.entry_index[ADDR_W-1:0];
            case (cfg.mode)
                MODE_INDEX:   r_value <= PIXEL_W'(i_pix.data.entry_index);
                MODE_PALETTE: r_value <= '0;
                default:      r_value <= {i_pix.data.red_level, i_pix.data.green_level,
                                          i_pix.data.blue_level};
            endcase
        end
    end

    // Output pixel
    assign fill_value = (cfg.mode == MODE_INDEX) ? '0 : WHITE_PIXEL;
    assign pix_value  = r_from_mem ? rd_data : r_value;

    assign i_pix.ready = (r_state == ST_IDLE);
    assign o_pix.valid = (r_state == ST_EMIT) || (r_state == ST_PAD);

    always_comb begin
        if (r_state == ST_PAD) begin
            o_pix.data.pixel_value = fill_value;
            o_pix.data.is_padding  = 1'b1;
            o_pix.data.row_last    = (r_pad_cnt == PAD_W'(1));
        end else begin
            o_pix.data.pixel_value = pix_value;
            o_pix.data.is_padding  = 1'b0;
            o_pix.data.row_last    = r_row_end && (r_pad_cnt == '0);
        end
    end

endmodule

FILE: bench/tb_palette_pixel_expander.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_pixel_expander
// Self-checking bench for the palette pixel expander. Palette writes and
// source pixels go in over a valid/ready channel, and a predictor of the
// row, padding and palette logic builds the expected output pixels. Each
// output transaction is compared field by field in order. The run works
// through directed corner settings, then random settings and items under
// three backpressure patterns.
// ----------------------------------------------------------------------------
module tb_palette_pixel_expander;
    import ppe_pkg::*;

    localparam int unsigned ENTRY_COUNT      = DEF_PALETTE_ENTRIES;
    localparam int unsigned ROW_LIMIT        = DEF_MAX_ROW_PIXELS;
    localparam logic [1:0]  MODE_RESERVED    = 2'd3;
    localparam int unsigned SETTLE_CYCLES    = 30;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS      = 32;

    logic i_clk;
    logic i_rst_n;

    ppe_pix_if pix_bus ();
    ppe_out_if out_bus ();
    ppe_cfg_if cfg_bus ();

    palette_pixel_expander u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_pix   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // Stimulus and expectation stores
    t_pix_in     pending_items[$];
    t_pix_out    expected_pixels[$];
    int unsigned filled_entries[$];
    bit          entry_filled[ENTRY_COUNT];

    // Predictor state
    t_cfg         model_cfg;
    logic [23:0]  palette_model[ENTRY_COUNT];
    int unsigned  row_column;

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    logic        out_hold;
    int unsigned mismatch_count;

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Scale a palette level of the given precision to a full byte
    function automatic logic [7:0] scale_to_byte(input logic [7:0] level,
                                                 input logic [3:0] bits);
        int unsigned prec;
        int unsigned top;
        int unsigned scaled;
        prec = bits;
        if (prec < 1) prec = 1;
        if (prec > 8) prec = 8;
        top    = (1 << prec) - 1;
        scaled = (level * 255) / top;
        return (scaled > 255) ? 8'hFF : scaled[7:0];
    endfunction

    // Update palette or row state for one accepted item, queue its pixels
    task automatic expand_source_item(input t_pix_in item);
        logic [23:0] value;
        logic [23:0] fill;
        logic [7:0]  green_src;
        logic [7:0]  blue_src;
        int unsigned width;
        t_pix_out    pix;
        if (item.kind == KIND_PALETTE_WR) begin
            green_src = model_cfg.grayscale ? item.red_level : item.green_level;
            blue_src  = model_cfg.grayscale ? item.red_level : item.blue_level;
            palette_model[item.entry_index] = {
                scale_to_byte(item.red_level, model_cfg.red_bits),
                scale_to_byte(green_src, model_cfg.green_bits),
                scale_to_byte(blue_src, model_cfg.blue_bits)};
            return;
        end
        case (t_mode'(model_cfg.mode))
            MODE_INDEX: begin
                value = {16'h0000, item.entry_index};
                fill  = '0;
            end
            MODE_PALETTE: begin
                value = palette_model[item.entry_index];
                fill  = WHITE_PIXEL;
            end
            default: begin
                // reserved mode behaves as direct RGB
                value = {item.red_level, item.green_level, item.blue_level};
                fill  = WHITE_PIXEL;
            end
        endcase
        width = model_cfg.image_width;
        if (width < 1) width = 1;
        if (width > ROW_LIMIT) width = ROW_LIMIT;
        pix.pixel_value = value;
        pix.is_padding  = 1'b0;
        if (row_column + 1 < width) begin
            row_column++;
            pix.row_last = 1'b0;
            expected_pixels.push_back(pix);
            return;
        end
        // row end, possibly lowered mid-row: close it and append padding
        row_column   = 0;
        pix.row_last = (model_cfg.pad_pixels == 0);
        expected_pixels.push_back(pix);
        for (int i = 0; i < model_cfg.pad_pixels; i++) begin
            pix.pixel_value = fill;
            pix.is_padding  = 1'b1;
            pix.row_last    = (i + 1 == model_cfg.pad_pixels);
            expected_pixels.push_back(pix);
        end
    endtask

    // Driver: present queued items, predict on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                expand_source_item(pix_bus.data);
            end
            if (!pix_bus.valid || pix_bus.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    pix_bus.valid <= 1'b1;
                    pix_bus.data  <= pending_items.pop_front();
                end else begin
                    pix_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each output transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, actual %h pad %b last %b",
                             $time, out_bus.data.pixel_value, out_bus.data.is_padding,
                             out_bus.data.row_last);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_bus.data.pixel_value !== want.pixel_value) begin
                        $display("%0t: pixel_value expected %h, actual %h",
                                 $time, want.pixel_value, out_bus.data.pixel_value);
                        mismatch_count++;
                    end
                    if (out_bus.data.is_padding !== want.is_padding) begin
                        $display("%0t: is_padding expected %b, actual %b",
                                 $time, want.is_padding, out_bus.data.is_padding);
                        mismatch_count++;
                    end
                    if (out_bus.data.row_last !== want.row_last) begin
                        $display("%0t: row_last expected %b, actual %b",
                                 $time, want.row_last, out_bus.data.row_last);
                        mismatch_count++;
                    end
                end
            end
            out_bus.ready <= !out_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Write one register; valid stays high for a following write
    task automatic write_register(input t_cfg_idx idx, input int unsigned val);
        t_cfg_wr wr;
        wr.index = idx;
        wr.value = val[CFG_DAT_W-1:0];
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= wr;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        case (idx)
            CFG_MODE:        model_cfg.mode        = val[1:0];
            CFG_IMAGE_WIDTH: model_cfg.image_width = val[IMG_W_W-1:0];
            CFG_PAD_PIXELS:  model_cfg.pad_pixels  = val[PAD_W-1:0];
            CFG_RED_BITS:    model_cfg.red_bits    = val[BITS_W-1:0];
            CFG_GREEN_BITS:  model_cfg.green_bits  = val[BITS_W-1:0];
            CFG_BLUE_BITS:   model_cfg.blue_bits   = val[BITS_W-1:0];
            CFG_GRAYSCALE:   model_cfg.grayscale   = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int unsigned mode, input int unsigned width,
                                  input int unsigned pad, input int unsigned red_b,
                                  input int unsigned green_b, input int unsigned blue_b,
                                  input int unsigned gray);
        write_register(CFG_MODE, mode);
        write_register(CFG_IMAGE_WIDTH, width);
        write_register(CFG_PAD_PIXELS, pad);
        write_register(CFG_RED_BITS, red_b);
        write_register(CFG_GREEN_BITS, green_b);
        write_register(CFG_BLUE_BITS, blue_b);
        write_register(CFG_GRAYSCALE, gray);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic queue_item(input logic kind, input int unsigned idx,
                              input int unsigned red, input int unsigned green,
                              input int unsigned blue);
        t_pix_in item;
        item.kind        = kind;
        item.entry_index = idx[7:0];
        item.red_level   = red[7:0];
        item.green_level = green[7:0];
        item.blue_level  = blue[7:0];
        // remember which entries exist so lookups never hit an empty one
        if (kind == KIND_PALETTE_WR && !entry_filled[idx[7:0]]) begin
            entry_filled[idx[7:0]] = 1'b1;
            filled_entries.push_back(idx[7:0]);
        end
        pending_items.push_back(item);
    endtask

    task automatic queue_random_items(input int unsigned count);
        int unsigned idx;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 20) begin
                queue_item(KIND_PALETTE_WR, $urandom_range(255), $urandom_range(255),
                           $urandom_range(255), $urandom_range(255));
            end else begin
                if (model_cfg.mode == MODE_PALETTE) begin
                    idx = filled_entries[$urandom_range(filled_entries.size() - 1)];
                end else begin
                    idx = $urandom_range(255);
                end
                queue_item(KIND_PIXEL, idx, $urandom_range(255), $urandom_range(255),
                           $urandom_range(255));
            end
        end
    endtask

    function automatic int unsigned random_bits();
        return ($urandom_range(99) < 70) ? $urandom_range(8, 1) : $urandom_range(15);
    endfunction

    task automatic apply_random_settings();
        int unsigned pick;
        int unsigned width;
        pick = $urandom_range(99);
        if (pick < 10)      width = 0;
        else if (pick < 80) width = $urandom_range(6, 1);
        else if (pick < 95) width = $urandom_range(40, 7);
        else                width = $urandom_range(8191, 4096);
        apply_settings($urandom_range(3), width, $urandom_range(15), random_bits(),
                       random_bits(), random_bits(), $urandom_range(1));
    endtask

    // Wait until every item is taken and every pixel has come out
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_items.size() != 0 || pix_bus.valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        // let a palette write with no output finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence
    initial begin
        model_cfg      = CFG_RESET;
        row_column     = 0;
        mismatch_count = 0;
        src_idle_pct   = 28;
        sink_idle_pct  = 56;
        out_hold       = 1'b0;
        i_rst_n        = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.data   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // palette lookup, extreme levels, short row with white padding
        apply_settings(MODE_PALETTE, 3, 2, 8, 8, 8, 0);
        queue_item(KIND_PALETTE_WR, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_item(KIND_PALETTE_WR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_item(KIND_PALETTE_WR, 8'h5A, 8'h80, 8'h7F, 8'h01);
        queue_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_item(KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00);
        queue_item(KIND_PIXEL, 8'h5A, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // reserved mode, zero width, most padding, clamped bit counts, grayscale
        apply_settings(MODE_RESERVED, 0, 15, 0, 15, 1, 1);
        queue_item(KIND_PALETTE_WR, 8'h01, 8'hFF, 8'h00, 8'h01);
        queue_item(KIND_PALETTE_WR, 8'h02, 8'h01, 8'hFF, 8'hFF);
        queue_item(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF);
        queue_item(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00);
        wait_drained();

        // width above the row limit, partial precision
        apply_settings(MODE_PALETTE, 8191, 1, 3, 5, 7, 0);
        queue_item(KIND_PALETTE_WR, 8'h03, 8'h07, 8'h1F, 8'h7F);
        queue_item(KIND_PALETTE_WR, 8'h04, 8'hFF, 8'h10, 8'h40);
        queue_item(KIND_PIXEL, 8'h03, 8'h00, 8'h00, 8'h00);
        queue_item(KIND_PIXEL, 8'h04, 8'h00, 8'h00, 8'h00);
        queue_item(KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // width lowered mid-row ends the row at once; index passthrough
        apply_settings(MODE_INDEX, 2, 1, 3, 5, 7, 0);
        queue_item(KIND_PIXEL, 8'hA5, 8'h00, 8'h00, 8'h00);
        queue_item(KIND_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        queue_item(KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00);
        wait_drained();

        // random settings and items under three backpressure patterns
        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin src_idle_pct = 28; sink_idle_pct = 56; end
                1: begin src_idle_pct = 56; sink_idle_pct = 28; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            for (int phase = 0; phase < 3; phase++) begin
                apply_random_settings();
                if (regime == 2 && phase == 0) begin
                    // hold off the output long enough to back up the input
                    fork
                        begin
                            out_hold = 1'b1;
                            repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                            out_hold = 1'b0;
                        end
                    join_none
                end
                queue_random_items(PHASE_ITEMS);
                wait_drained();
            end
        end

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
rtl/ppe_pkg.sv
rtl/ppe_ifs.sv
rtl/ppe_cfg_regs.sv
rtl/ppe_level_div.sv
rtl/ppe_palette_mem.sv
rtl/palette_pixel_expander.sv
bench/tb_palette_pixel_expander.sv
